/* sv/spf_pkg.sv */
package spf_pkg;

  localparam logic [7:0]  START_BYTE = 8'h02;
  localparam logic [7:0]  STOP_BYTE  = 8'h03;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          QUEUE_DEPTH_DEF = 4;

  // what the back end has to emit for one request
  typedef enum logic [2:0] {
    JOB_HDR,
    JOB_HDR_EMPTY,
    JOB_DATA,
    JOB_DATA_LAST,
    JOB_ERR
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] crc;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // crc16-xmodem, msb first, one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/spf_if.sv */
interface spf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] frame_length;
  logic [7:0] data_byte;

  modport source (output valid, output op, output frame_length, output data_byte,
                  input ready);
  modport sink (input valid, input op, input frame_length, input data_byte,
                output ready);
endinterface

interface spf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       error;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  output error, input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                input error, output ready);
endinterface

/* sv/short_packet_framer_crc16.sv */
// short packet framer with crc16-xmodem trailer
// in_ch takes one request per cycle while ready is high: op 0 is a header
// carrying frame_length, op 1 a payload byte. out_ch gives the framed bytes
// one per cycle while not stalled, run_last marking a request's last byte.
// a header gives start byte and length (two bytes); a zero length header
// gives start, 00, 00, 00, stop (five bytes). a payload byte gives one byte,
// or the byte plus crc high, crc low and stop (four bytes) when it completes
// the frame. a payload byte with no frame open gives one byte 00 with error.
// a request is queued first; its bytes then pass the output byte register.
// throughput: one payload request per cycle when not stalled; each request
// sends its bytes (1, 2, 4 or 5) in turn via the single output byte register.
// the QUEUE_DEPTH request queue lets the input side run ahead of the trailer
// bytes; ready drops only when that queue is full.
// reset (synchronous, rst_n low) empties the queue, closes any frame and
// clears the crc. if out_ch.ready is low the current byte holds, the queue
// fills and in_ch.ready then drops until bytes move again.
module short_packet_framer_crc16 #(
  parameter int QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spf_in_if.sink    in_ch,
  spf_out_if.source out_ch
);
  import spf_pkg::*;

  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head_job;
  q_status_t q_status;

  spf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  spf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  spf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

/* sv/spf_front.sv */
module spf_front (
  input  logic              clk,
  input  logic              rst_n,
  spf_in_if.sink            in_ch,
  input  spf_pkg::q_status_t q_status,
  output logic              push,
  output spf_pkg::job_t     push_job
);
  import spf_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  remaining_r, remaining_nxt;
  logic        open_r, open_nxt;
  logic [15:0] crc_folded;
  logic [7:0]  remaining_dec;

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && in_ch.ready;

  assign crc_folded    = crc_fold(crc_r, in_ch.data_byte);
  assign remaining_dec = remaining_r - 8'd1;

  always_comb begin
    crc_nxt       = crc_r;
    remaining_nxt = remaining_r;
    open_nxt      = open_r;
    push_job.kind = JOB_ERR;
    push_job.data = 8'h00;
    push_job.crc  = 16'h0000;
    if (!in_ch.op) begin
      // header: a zero length closes the frame right away
      crc_nxt       = 16'h0000;
      remaining_nxt = in_ch.frame_length;
      open_nxt      = (in_ch.frame_length != 8'h00);
      push_job.kind = (in_ch.frame_length == 8'h00) ? JOB_HDR_EMPTY : JOB_HDR;
      push_job.data = in_ch.frame_length;
    end else if (open_r) begin
      crc_nxt       = crc_folded;
      push_job.data = in_ch.data_byte;
      push_job.crc  = crc_folded;
      if (remaining_dec == 8'h00) begin
        push_job.kind = JOB_DATA_LAST;
        open_nxt      = 1'b0;
        remaining_nxt = 8'h00;
      end else begin
        push_job.kind = JOB_DATA;
        remaining_nxt = remaining_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 16'h0000;
      remaining_r <= 8'h00;
      open_r      <= 1'b0;
    end else if (push) begin
      crc_r       <= crc_nxt;
      remaining_r <= remaining_nxt;
      open_r      <= open_nxt;
    end
  end

endmodule

/* sv/spf_queue.sv */
module spf_queue #(
  parameter int DEPTH = spf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spf_pkg::job_t      push_job,
  input  logic               pop,
  output spf_pkg::job_t      head_job,
  output spf_pkg::q_status_t q_status
);
  import spf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_status.full  = (count_r == CNT_FULL);
  assign q_status.empty = (count_r == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* sv/spf_back.sv */
module spf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  spf_pkg::job_t      head_job,
  input  spf_pkg::q_status_t q_status,
  output logic               pop,
  spf_out_if.source          out_ch
);
  import spf_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, end_r, err_r;
  logic       load;
  logic [7:0] cur_byte;
  logic       cur_done, cur_end, cur_err;

  assign out_ch.valid     = valid_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.run_last  = last_r;
  assign out_ch.frame_end = end_r;
  assign out_ch.error     = err_r;

  assign load = !q_status.empty && (!valid_r || out_ch.ready);
  assign pop  = load && cur_done;

  // byte sequence per request kind, indexed by step
  always_comb begin
    cur_byte = 8'h00;
    cur_done = 1'b0;
    cur_end  = 1'b0;
    cur_err  = 1'b0;
    case (head_job.kind)
      JOB_HDR: begin
        cur_byte = (step_r == 3'd0) ? START_BYTE : head_job.data;
        cur_done = (step_r != 3'd0);
      end
      JOB_HDR_EMPTY: begin
        case (step_r)
          3'd0:    cur_byte = START_BYTE;
          3'd1:    cur_byte = 8'h00;
          3'd2:    cur_byte = head_job.crc[15:8];
          3'd3:    cur_byte = head_job.crc[7:0];
          default: begin
            cur_byte = STOP_BYTE;
            cur_done = 1'b1;
            cur_end  = 1'b1;
          end
        endcase
      end
      JOB_DATA: begin
        cur_byte = head_job.data;
        cur_done = 1'b1;
      end
      JOB_DATA_LAST: begin
        case (step_r)
          3'd0:    cur_byte = head_job.data;
          3'd1:    cur_byte = head_job.crc[15:8];
          3'd2:    cur_byte = head_job.crc[7:0];
          default: begin
            cur_byte = STOP_BYTE;
            cur_done = 1'b1;
            cur_end  = 1'b1;
          end
        endcase
      end
      default: begin
        cur_byte = 8'h00;
        cur_done = 1'b1;
        cur_err  = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = cur_done ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 3'd0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= cur_done;
      end_r  <= cur_end;
      err_r  <= cur_err;
    end
  end

endmodule

/* sv/spf_checker.sv */
module spf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       frame_end,
  input logic       error
);

  // a stalled byte stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last)
      && $stable(frame_end) && $stable(error))
    else $error("output payload changed under stall");

  // stop byte always closes the request's run
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> run_last && !error && out_byte == 8'h03)
    else $error("bad stop byte result");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error |-> run_last && !frame_end && out_byte == 8'h00)
    else $error("bad error result");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind short_packet_framer_crc16 spf_checker u_spf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_last  (out_ch.run_last),
  .frame_end (out_ch.frame_end),
  .error     (out_ch.error)
);

/* verif/tb_short_packet_framer_crc16.sv */
module tb_short_packet_framer_crc16;
  import spf_pkg::*;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;
  localparam int   N_DIRECTED = 24;
  localparam int   N_ITEMS    = 320;
  localparam int   LONG_FRAME = 255;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       error;
  } wire_byte_t;

  typedef wire_byte_t [0:4] wire_seq_t;

  typedef struct packed {
    logic       op;
    logic [7:0] frame_length;
    logic [7:0] data_byte;
    logic [2:0] fixed_n;    // bytes typed in by hand, 0 when predicted
    wire_seq_t  fixed_seq;
  } framer_req_t;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  localparam wire_seq_t NO_SEQ = '0;

  logic clk;
  logic rst_n;

  spf_in_if  in_ch();
  spf_out_if out_ch();

  short_packet_framer_crc16 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predicted framer state
  logic [15:0] frame_crc;
  logic [7:0]  frame_left;
  logic        frame_live;

  framer_req_t request_plan[$];
  framer_req_t directed_rows [N_DIRECTED];
  wire_byte_t  pending_bytes[$];
  wire_seq_t   err_seq;
  wire_seq_t   empty_seq;
  int          mismatches    = 0;
  int          accepted_reqs = 0;

  function automatic wire_byte_t wb(logic [7:0] b, logic last, logic fend, logic err);
    wire_byte_t w;
    w.out_byte  = b;
    w.run_last  = last;
    w.frame_end = fend;
    w.error     = err;
    return w;
  endfunction

  function automatic framer_req_t req_row(logic op, logic [7:0] len, logic [7:0] db,
                                          logic [2:0] n, wire_seq_t seq);
    framer_req_t r;
    r.op           = op;
    r.frame_length = len;
    r.data_byte    = db;
    r.fixed_n      = n;
    r.fixed_seq    = seq;
    return r;
  endfunction

  // bitwise xmodem update, data bit by data bit
  function automatic logic [15:0] xmodem_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  function automatic void frame_bytes_for(input logic op, input logic [7:0] len,
                                          input logic [7:0] db, output int n,
                                          output wire_seq_t seq);
    logic closing;
    closing = 1'b0;
    n       = 0;
    seq     = '0;
    if (op == OP_HEADER) begin
      frame_crc  = '0;
      frame_left = len;
      frame_live = 1'b1;
      seq[0]     = wb(START_BYTE, 1'b0, 1'b0, 1'b0);
      seq[1]     = wb(len, len != 8'd0, 1'b0, 1'b0);
      n          = 2;
      closing    = (len == 8'd0);
    end else if (!frame_live) begin
      seq[0] = wb(8'h00, 1'b1, 1'b0, 1'b1);
      n      = 1;
    end else begin
      frame_crc  = xmodem_step(frame_crc, db);
      frame_left = frame_left - 8'd1;
      closing    = (frame_left == 8'd0);
      seq[0]     = wb(db, !closing, 1'b0, 1'b0);
      n          = 1;
    end
    if (closing) begin
      seq[n]     = wb(frame_crc[15:8], 1'b0, 1'b0, 1'b0);
      seq[n + 1] = wb(frame_crc[7:0], 1'b0, 1'b0, 1'b0);
      seq[n + 2] = wb(STOP_BYTE, 1'b1, 1'b1, 1'b0);
      n          = n + 3;
      frame_live = 1'b0;
      frame_left = 8'd0;
    end
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    end
  endtask

  always @(posedge clk) begin : wire_check
    int          n;
    wire_seq_t   seq;
    framer_req_t req;
    wire_byte_t  want;
    if (rst_n === 1'b1) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        req = request_plan[accepted_reqs];
        frame_bytes_for(in_ch.op, in_ch.frame_length, in_ch.data_byte, n, seq);
        if (req.fixed_n != 3'd0) begin
          n   = int'(req.fixed_n);
          seq = req.fixed_seq;
        end
        for (int i = 0; i < n; i++) begin
          pending_bytes.push_back(seq[i]);
        end
        accepted_reqs++;
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_bytes.size() == 0) begin
          note_mismatch($sformatf("byte %02h with nothing expected", out_ch.out_byte));
        end else begin
          want = pending_bytes.pop_front();
          check_field("out_byte", out_ch.out_byte, want.out_byte);
          check_field("run_last", 8'(out_ch.run_last), 8'(want.run_last));
          check_field("frame_end", 8'(out_ch.frame_end), 8'(want.frame_end));
          check_field("error", 8'(out_ch.error), 8'(want.error));
        end
      end
    end
  end

  initial begin : sender
    int burst_left;
    int gap;
    int len;
    int cut;
    int pick;
    int spin;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_HEADER;
    in_ch.frame_length = 8'h00;
    in_ch.data_byte    = 8'h00;
    frame_crc          = '0;
    frame_left         = '0;
    frame_live         = 1'b0;

    err_seq   = {wb(8'h00, 1'b1, 1'b0, 1'b1), 44'h0};
    empty_seq = {wb(START_BYTE, 1'b0, 1'b0, 1'b0), wb(8'h00, 1'b0, 1'b0, 1'b0),
                 wb(8'h00, 1'b0, 1'b0, 1'b0), wb(8'h00, 1'b0, 1'b0, 1'b0),
                 wb(STOP_BYTE, 1'b1, 1'b1, 1'b0)};

    directed_rows = '{
      // payload right after reset, no frame open
      req_row(OP_PAYLOAD, 8'hFF, 8'h5A, 3'd1, err_seq),
      req_row(OP_HEADER,  8'h00, 8'hFF, 3'd5, empty_seq),
      req_row(OP_HEADER,  8'hFF, 8'h00, 3'd2,
              {wb(START_BYTE, 1'b0, 1'b0, 1'b0), wb(8'hFF, 1'b1, 1'b0, 1'b0), 33'h0}),
      req_row(OP_PAYLOAD, 8'h00, 8'h00, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'hFF, 8'hFF, 3'd0, NO_SEQ),
      // new header drops the long frame without a trailer
      req_row(OP_HEADER,  8'h01, 8'hC3, 3'd2,
              {wb(START_BYTE, 1'b0, 1'b0, 1'b0), wb(8'h01, 1'b1, 1'b0, 1'b0), 33'h0}),
      req_row(OP_PAYLOAD, 8'h80, 8'hA5, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h3C, 3'd1, err_seq),
      req_row(OP_HEADER,  8'h03, 8'hFF, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h31, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h32, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h33, 3'd0, NO_SEQ),
      req_row(OP_HEADER,  8'h02, 8'h00, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h55, 8'h00, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'hAA, 8'hFF, 3'd0, NO_SEQ),
      req_row(OP_HEADER,  8'h01, 8'h00, 3'd0, NO_SEQ),
      // zero length header inside an open frame
      req_row(OP_HEADER,  8'h00, 8'h00, 3'd5, empty_seq),
      req_row(OP_PAYLOAD, 8'h00, 8'hFF, 3'd1, err_seq),
      req_row(OP_HEADER,  8'h04, 8'h00, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h80, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h01, 3'd0, NO_SEQ),
      req_row(OP_HEADER,  8'h02, 8'h00, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'h7F, 3'd0, NO_SEQ),
      req_row(OP_PAYLOAD, 8'h00, 8'hFE, 3'd0, NO_SEQ)
    };
    foreach (directed_rows[i]) begin
      request_plan.push_back(directed_rows[i]);
    end

    // one frame at full length, counting the length down from 255
    request_plan.push_back(req_row(OP_HEADER, 8'(LONG_FRAME), 8'($urandom), 3'd0, NO_SEQ));
    for (int i = 0; i < LONG_FRAME; i++) begin
      request_plan.push_back(req_row(OP_PAYLOAD, 8'($urandom), 8'($urandom), 3'd0, NO_SEQ));
    end

    // mostly complete frames with random bytes, some empty, cut short or stray
    while (request_plan.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 93) begin
        if (pick < 78) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
          cut = len;
        end else if (pick < 86) begin
          len = 0;
          cut = 0;
        end else begin
          len = $urandom_range(2, 12);
          cut = $urandom_range(0, len - 1);
        end
        request_plan.push_back(req_row(OP_HEADER, 8'(len), 8'($urandom), 3'd0, NO_SEQ));
      end else begin
        cut = $urandom_range(1, 3);
      end
      for (int i = 0; i < cut; i++) begin
        request_plan.push_back(req_row(OP_PAYLOAD, 8'($urandom), 8'($urandom), 3'd0, NO_SEQ));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    foreach (request_plan[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_ch.valid        <= 1'b1;
      in_ch.op           <= request_plan[i].op;
      in_ch.frame_length <= request_plan[i].frame_length;
      in_ch.data_byte    <= request_plan[i].data_byte;
      @(posedge clk);
      while (in_ch.ready !== 1'b1) @(posedge clk);
      burst_left--;
    end
    in_ch.valid <= 1'b0;

    spin = 0;
    while (pending_bytes.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      note_mismatch($sformatf("%0d expected bytes never came out", pending_bytes.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    int       hold_left;
    bit       hold_done;
    out_ch.ready = 1'b0;
    mode         = RX_FREE;
    mode_left    = 0;
    phase        = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && accepted_reqs >= 120) begin
        // long hold so the request queue fills and input ready drops
        hold_done = 1'b1;
        hold_left = 79;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_FREE: begin
            out_ch.ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_ch.ready <= ($urandom_range(0, 9) >= 3);
          end
          default: begin
            out_ch.ready <= ((phase % 5) >= 2);
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
